// ----- design/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
// No dependencies; imported by table_linear_interpolator and tli_div.
package tli_pkg;

  localparam int ValueW  = 32;
  localparam int WeightW = 17;
  localparam int FracW   = 16;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;

  typedef enum logic [1:0] {
    CFG_TIME_OFFSET = 2'd0,
    CFG_ROW_COUNT   = 2'd1,
    CFG_TIME_COLUMN = 2'd2
  } cfg_reg_t;

  typedef enum logic [StatusW-1:0] {
    POS_INSIDE    = 2'd0,
    POS_BELOW     = 2'd1,
    POS_ABOVE     = 2'd2,
    POS_NOT_FOUND = 2'd3
  } pos_status_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_X0, ST_XL, ST_DECIDE, ST_SA, ST_SB, ST_SC, ST_DIV,
    ST_VL, ST_VU, ST_M1, ST_M2, ST_FIN
  } tli_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic                done;
    logic [FracW-1:0]    quotient;
  } div_sts_t;

endpackage

// ----- design/table_linear_interpolator.sv -----
// Table linear interpolator: loads a Q16.16 table, answers interpolation queries.
// Depends on tli_pkg, tli_ram, tli_div.
//
// Usage:
//   Input stream s_*: tuser = req_type (0 load, 1 query). tdata carries
//   row_index, column_index, entry_value, query_time and restart.
//   A load writes one table entry; it returns nothing.
//   A query returns one transaction on m_*: value, lower row, Q1.16 weight
//   of the upper row and a position status.
//   Config channel cfg_*: always ready; index 0 query time offset,
//   1 row_count, 2 time_column. Write only while the block is idle.
// Sequencing:
//   The table sits in one RAM with a registered read port; every abscissa
//   and value comes through that port. A clamped query skips the search;
//   an inside query walks rows from the cursor and then waits for the
//   serial divider. Only one item is in flight; s_tready is high while idle.
// Stall: a finished result waits in the output register; the next item is
//   still taken, and a later result waits until m_tready frees that register.
// Reset: clears control state, registers to reset values, cursor and weight;
//   the table is undefined until written.
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] row_index, [10:8] column_index, [42:11] entry_value,
  // [74:43] query_time, [75] restart, [79:76] zero
  input  logic [79:0] s_tdata,
  // [0] req_type
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] result_value, [39:32] lower_row, [56:40] upper_weight,
  // [58:57] position_status, [63:59] zero
  output logic [63:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(Depth);
  localparam int RW    = $clog2(MAX_ROWS);

  // Configuration registers
  logic signed [31:0] query_bias;
  logic [8:0]         row_count;
  logic [2:0]         time_column;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_bias  <= '0;
      row_count   <= 9'd1;
      time_column <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TIME_OFFSET: query_bias  <= cfg_data;
        CFG_ROW_COUNT:   row_count   <= cfg_data[8:0];
        CFG_TIME_COLUMN: time_column <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Last row in use, with row_count clamped to 1..MAX_ROWS
  logic [RW-1:0] last_row;
  always_comb begin
    if (row_count == 9'd0) begin
      last_row = '0;
    end else if (32'(row_count) > MAX_ROWS) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(32'(row_count) - 32'd1);
    end
  end

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [2:0] c);
    cell_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  // Input field split
  logic [7:0]         in_row;
  logic [2:0]         in_col;
  logic [31:0]        in_entry;
  logic signed [31:0] in_time;
  logic               in_restart;
  logic               in_accept;

  assign in_row     = s_tdata[7:0];
  assign in_col     = s_tdata[10:8];
  assign in_entry   = s_tdata[42:11];
  assign in_time    = s_tdata[74:43];
  assign in_restart = s_tdata[75];
  assign in_accept  = s_tvalid && s_tready;

  // Sequencer state and datapath registers
  tli_state_t         st, st_next;
  logic [RW-1:0]      cur_lo, cur_up;
  logic [WeightW-1:0] weight;
  logic [RW-1:0]      idx;
  logic [2:0]         qcol;
  logic signed [32:0] t;
  logic signed [31:0] x0, xa;
  logic signed [31:0] lo_v, up_v;
  logic signed [49:0] p0, p1;
  pos_status_t        status;

  logic               m_valid;
  logic [63:0]        m_data;

  logic               tcol_ok, qcol_ok;
  logic [31:0]        rdata;
  logic signed [31:0] xval, vval;
  logic [AW-1:0]      raddr;
  logic               we;

  assign tcol_ok = 32'(time_column) < MAX_COLS;
  assign qcol_ok = 32'(qcol) < MAX_COLS;
  assign xval    = tcol_ok ? signed'(rdata) : '0;
  assign vval    = qcol_ok ? signed'(rdata) : '0;

  assign we = in_accept && (req_type_t'(s_tuser[0]) == REQ_LOAD)
              && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

  tli_ram #(.Width(ValueW), .Depth(Depth)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cell_addr(RW'(in_row), in_col)),
    .wdata (in_entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Interval tests
  logic below, above, hit, search_end;
  logic [RW:0] idx_inc;
  assign below      = t < 33'(x0);
  assign above      = t >= 33'(xval);
  assign hit        = (t >= 33'(xa)) && (t < 33'(xval));
  assign idx_inc    = {1'b0, idx} + 1'b1;
  assign search_end = (idx_inc + 1'b1) > {1'b0, last_row};

  // Divider
  div_ctl_t     div_ctl;
  div_sts_t     div_sts;
  logic [33:0]  num_w, den_w;
  assign num_w = 34'(t) - 34'(xa);
  assign den_w = 34'(33'(xval)) - 34'(33'(xa));
  assign div_ctl.start = (st == ST_SC) && hit;

  tli_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (num_w[32:0]),
    .den (den_w[32:0]),
    .sts (div_sts)
  );

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (in_accept && (req_type_t'(s_tuser[0]) == REQ_QUERY)) begin
          st_next = ST_X0;
        end
      end
      ST_X0:     st_next = ST_XL;
      ST_XL:     st_next = ST_DECIDE;
      ST_DECIDE: begin
        if (below || above || (cur_lo >= last_row)) begin
          st_next = ST_VL;
        end else begin
          st_next = ST_SA;
        end
      end
      ST_SA:     st_next = ST_SB;
      ST_SB:     st_next = ST_SC;
      ST_SC: begin
        if (hit) begin
          st_next = ST_DIV;
        end else if (search_end) begin
          st_next = ST_VL;
        end else begin
          st_next = ST_SA;
        end
      end
      ST_DIV:    st_next = div_sts.done ? ST_VL : ST_DIV;
      ST_VL:     st_next = ST_VU;
      ST_VU:     st_next = ST_M1;
      ST_M1:     st_next = ST_M2;
      ST_M2:     st_next = ST_FIN;
      ST_FIN:    st_next = (!m_valid || m_tready) ? ST_IDLE : ST_FIN;
      default:   st_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: read address and input ready
  always_comb begin
    raddr = '0;
    unique case (st)
      ST_X0:   raddr = cell_addr('0, time_column);
      ST_XL:   raddr = cell_addr(last_row, time_column);
      ST_SA:   raddr = cell_addr(idx, time_column);
      ST_SB:   raddr = cell_addr(idx_inc[RW-1:0], time_column);
      ST_VL:   raddr = cell_addr(cur_lo, qcol);
      ST_VU:   raddr = cell_addr(cur_up, qcol);
      default: raddr = '0;
    endcase
  end

  assign s_tready = (st == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Cursor and weight
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_lo <= '0;
      cur_up <= '0;
      weight <= '0;
    end else begin
      if (st == ST_IDLE && in_accept && (req_type_t'(s_tuser[0]) == REQ_QUERY)
          && in_restart) begin
        cur_lo <= '0;
        cur_up <= '0;
        weight <= '0;
      end
      if (st == ST_DECIDE) begin
        if (below) begin
          cur_lo <= '0;
          cur_up <= '0;
          weight <= '0;
        end else if (above) begin
          cur_lo <= last_row;
          cur_up <= last_row;
          weight <= '0;
        end
      end
      if (st == ST_DIV && div_sts.done) begin
        cur_lo <= idx;
        cur_up <= idx_inc[RW-1:0];
        weight <= {1'b0, div_sts.quotient};
      end
    end
  end

  // Datapath registers; no reset needed
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && in_accept) begin
      qcol <= in_col;
      t    <= 33'(in_time) + 33'(query_bias);
    end
    if (st == ST_XL) begin
      x0 <= xval;
    end
    if (st == ST_DECIDE) begin
      idx <= cur_lo;
      if (below) begin
        status <= POS_BELOW;
      end else if (above) begin
        status <= POS_ABOVE;
      end else begin
        status <= POS_NOT_FOUND;
      end
    end
    if (st == ST_SB) begin
      xa <= xval;
    end
    if (st == ST_SC) begin
      if (hit) begin
        status <= POS_INSIDE;
      end else begin
        idx <= idx_inc[RW-1:0];
      end
    end
    if (st == ST_VU) begin
      lo_v <= vval;
    end
    if (st == ST_M1) begin
      up_v <= vval;
      p0   <= lo_v * signed'({1'b0, 17'(18'd65536 - 18'(weight))});
    end
    if (st == ST_M2) begin
      p1 <= up_v * signed'({1'b0, weight});
    end
  end

  // Blend, round and saturate
  logic signed [50:0] sum;
  logic signed [34:0] quo;
  logic [31:0]        sat;
  assign sum = 51'(p0) + 51'(p1) + 51'sd32768;
  assign quo = 35'(sum >>> FracW);
  always_comb begin
    if (quo > 35'sd2147483647) begin
      sat = 32'h7FFF_FFFF;
    end else if (quo < -35'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = quo[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (st == ST_FIN && (!m_valid || m_tready)) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_FIN && (!m_valid || m_tready)) begin
      m_data <= {5'd0, status, weight, 8'(cur_lo), sat};
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = m_data;

`ifndef ASSERT_OFF
  a_cursor_pair: assert property (@(posedge clk) disable iff (rst)
    (cur_up == cur_lo) || ({1'b0, cur_up} == {1'b0, cur_lo} + 1'b1))
    else $error("cursor rows not adjacent");

  a_weight_pair: assert property (@(posedge clk) disable iff (rst)
    (weight != '0) |-> ({1'b0, cur_up} == {1'b0, cur_lo} + 1'b1))
    else $error("nonzero weight with clamped cursor");

  a_div_follow: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |=> (st == ST_DIV) && !div_sts.done)
    else $error("divider start without division state");
`endif

endmodule

// ----- design/tli_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tli_div.sv -----
// Restoring divider: one quotient bit per cycle, FracW bits of fraction.
// Depends on tli_pkg. Requires numerator < denominator.
module tli_div
  import tli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctl_t    ctl,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output div_sts_t    sts
);

  logic [33:0]        rem;
  logic [32:0]        dvs;
  logic [FracW-1:0]   quo;
  logic [4:0]         cnt;
  logic               busy;
  logic [34:0]        shifted;
  logic               take;

  assign shifted = {rem, 1'b0};
  assign take    = shifted >= {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= 5'(FracW);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= {1'b0, num};
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? 34'(shifted - {2'b00, dvs}) : shifted[33:0];
      quo <= {quo[FracW-2:0], take};
    end
  end

  assign sts.done     = !busy && !ctl.start;
  assign sts.quotient = quo;

endmodule
